[rtl/cll_pkg.sv]
// Shared constants and types for the circular list block.
package cll_pkg;

    localparam int Depth     = 256;
    localparam int AddrWidth = 8;
    localparam int DataWidth = 32;
    localparam int CountWidth = 9;

    typedef logic [AddrWidth-1:0]  slot_t;
    typedef logic [DataWidth-1:0]  word_t;
    typedef logic [CountWidth-1:0] count_t;

    typedef enum logic [3:0] {
        CMD_INS_AFTER  = 4'd0,
        CMD_INS_BEFORE = 4'd1,
        CMD_RM_AFTER   = 4'd2,
        CMD_RM_CURRENT = 4'd3,
        CMD_RM_BEFORE  = 4'd4,
        CMD_MOVE       = 4'd5,
        CMD_MAX        = 4'd6,
        CMD_MIN        = 4'd7,
        CMD_CONTAINS   = 4'd8,
        CMD_CLEAR      = 4'd9
    } cmd_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        word_t       operand_value;
        logic [15:0] step_count;
    } in_word_t;

    typedef struct packed {
        logic [1:0] status;
        word_t      data_out;
        logic       found;
        count_t     element_count;
        word_t      current_word;
        word_t      previous_word;
        word_t      following_word;
    } out_word_t;

endpackage

[rtl/cll_stream_if.sv]
// Valid/ready channel carrying one payload word.
interface cll_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/circular_list_with_cursor_core.sv]
// Top level of the circular list with cursor.
//
// A bounded circular doubly linked list of 32-bit words kept in slot memory
// (data, next and prev, 256 slots each, registered reads), with a cursor.
// One command word is worked at a time. An insert reads the cursor entry,
// writes the new entry and, unless the list was empty, patches the links
// of its neighbours; a remove reads the cursor entry and then the victim,
// joins the victim's neighbours and returns its slot to the free stack.
// Status-only outcomes (full, empty, clear, unused codes) go straight from
// decode to the result reads. A move first reduces its step count modulo
// the length by repeated subtraction, then steps the cursor one element
// at a time, backward for a negative count. Max, min and contains walk
// the whole ring from the cursor, reading each element in turn along the
// next pointers. After each command the words at, before and after the
// cursor are read and the result register is loaded. Clear resets the
// free-slot stack at once through a fill count: slots never handed out
// are given out in order, so no clearing pass is needed. The result word
// sits in an output register; the next command is taken once the result
// has left. The length limit may be written while the block is idle; a
// nonzero limit below the current length is ignored.
module circular_list_with_cursor_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [8:0]    cfg_wdata,
    cll_stream_if.sink    in_ch,
    cll_stream_if.source  out_ch
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_INS_RD, S_INS_W1, S_INS_W2, S_INS_W3,
        S_RM_RD1, S_RM_RD2, S_RM_W1, S_RM_W2,
        S_MOD, S_MV_RD, S_MV_WAIT,
        S_SC_RD, S_SC_WAIT,
        S_VW_CUR, S_VW_PREV, S_VW_NEXT, S_VW_PWORD, S_VW_NWORD, S_VW_DONE, S_OUT
    } state_t;

    state_t state_reg;

    // slot memories
    cll_pkg::word_t mem_data [cll_pkg::Depth];
    cll_pkg::slot_t mem_next [cll_pkg::Depth];
    cll_pkg::slot_t mem_prev [cll_pkg::Depth];
    cll_pkg::slot_t free_stack [cll_pkg::Depth];

    cll_pkg::word_t rd_data_reg;
    cll_pkg::slot_t rd_next_reg, rd_prev_reg, fs_rd_reg;

    cll_pkg::slot_t  rd_addr;
    logic            d_we, n_we, p_we, fs_we;
    cll_pkg::slot_t  d_wa, n_wa, p_wa, fs_wa;
    cll_pkg::slot_t  n_wd, p_wd, fs_wd;
    cll_pkg::word_t  d_wd;
    cll_pkg::slot_t  fs_ra;

    always_ff @(posedge clk)
    begin
        if (d_we) mem_data[d_wa] <= d_wd;
        if (n_we) mem_next[n_wa] <= n_wd;
        if (p_we) mem_prev[p_wa] <= p_wd;
        if (fs_we) free_stack[fs_wa] <= fs_wd;
        rd_data_reg <= mem_data[rd_addr];
        rd_next_reg <= mem_next[rd_addr];
        rd_prev_reg <= mem_prev[rd_addr];
        fs_rd_reg   <= free_stack[fs_ra];
    end

    // control and working registers
    cll_pkg::count_t limit_reg, len_reg, free_reg, fresh_reg;
    cll_pkg::slot_t  cur_reg, addr_reg, tgt_reg, a_reg, b_reg, new_reg;
    cll_pkg::in_word_t cmd_reg;
    cll_pkg::out_word_t res_reg;
    logic [16:0] mag_reg;
    logic        back_reg;
    cll_pkg::count_t cnt_reg;
    logic        found_reg;
    cll_pkg::word_t acc_reg;
    logic [1:0]  status_reg;
    cll_pkg::word_t dout_reg;

    logic is_full;
    logic [16:0] mag_init;
    cll_pkg::slot_t pop_slot;

    assign is_full = ((limit_reg != '0) && (len_reg >= limit_reg))
        || (len_reg >= cll_pkg::CountWidth'(cll_pkg::Depth)) || (free_reg == '0);
    assign mag_init = cmd_reg.step_count[15]
        ? (17'h10000 - {1'b0, cmd_reg.step_count}) : {1'b0, cmd_reg.step_count};
    // free stack entries above the fill mark hold returned slots; below it the untouched order is used
    assign fs_ra = cll_pkg::AddrWidth'(free_reg - 9'd1);
    assign pop_slot = (free_reg > fresh_reg) ? fs_rd_reg
        : cll_pkg::AddrWidth'(9'd255 - (free_reg - 9'd1));

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.payload = res_reg;

    always_comb
    begin
        rd_addr = addr_reg;
        d_we = 1'b0; n_we = 1'b0; p_we = 1'b0; fs_we = 1'b0;
        d_wa = new_reg; n_wa = new_reg; p_wa = new_reg; fs_wa = '0;
        d_wd = cmd_reg.operand_value; n_wd = b_reg; p_wd = a_reg; fs_wd = tgt_reg;
        unique case (state_reg)
            S_INS_W1:
            begin
                d_we = 1'b1;
                n_we = 1'b1;
                p_we = 1'b1;
            end
            S_INS_W2:
            begin
                n_we = 1'b1; n_wa = a_reg; n_wd = new_reg;
                p_we = 1'b1; p_wa = b_reg; p_wd = new_reg;
            end
            S_RM_W1:
            begin
                // victim entry is on the read port: join its neighbors
                n_we = (len_reg != 9'd1); n_wa = rd_prev_reg; n_wd = rd_next_reg;
                p_we = (len_reg != 9'd1); p_wa = rd_next_reg; p_wd = rd_prev_reg;
                fs_we = 1'b1; fs_wa = cll_pkg::AddrWidth'(free_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= '0;
            len_reg   <= '0;
            free_reg  <= 9'd256;
            fresh_reg <= 9'd256;
            cur_reg   <= '0;
        end
        else
        begin
            if (cfg_we && !((cfg_wdata != '0) && (len_reg > cfg_wdata)))
                limit_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid)
                    begin
                        cmd_reg    <= in_ch.payload;
                        addr_reg   <= cur_reg;
                        state_reg  <= S_DECODE;
                    end
                S_DECODE:
                begin
                    // cursor entry is read now
                    status_reg <= cll_pkg::STATUS_OK;
                    dout_reg   <= '0;
                    found_reg  <= 1'b0;
                    case (cmd_reg.command)
                        cll_pkg::CMD_INS_AFTER, cll_pkg::CMD_INS_BEFORE:
                            if (is_full)
                            begin
                                status_reg <= cll_pkg::STATUS_FULL;
                                state_reg  <= S_VW_CUR;
                            end
                            else
                                state_reg <= S_INS_RD;
                        cll_pkg::CMD_RM_AFTER, cll_pkg::CMD_RM_CURRENT,
                        cll_pkg::CMD_RM_BEFORE, cll_pkg::CMD_MOVE,
                        cll_pkg::CMD_MAX, cll_pkg::CMD_MIN:
                            if (len_reg == '0)
                            begin
                                status_reg <= cll_pkg::STATUS_EMPTY;
                                state_reg  <= S_VW_CUR;
                            end
                            else if (cmd_reg.command == cll_pkg::CMD_MOVE)
                            begin
                                mag_reg   <= mag_init;
                                back_reg  <= cmd_reg.step_count[15];
                                state_reg <= S_MOD;
                            end
                            else if (cmd_reg.command == cll_pkg::CMD_MAX
                                     || cmd_reg.command == cll_pkg::CMD_MIN)
                            begin
                                cnt_reg   <= len_reg;
                                acc_reg   <= '0;
                                addr_reg  <= cur_reg;
                                state_reg <= S_SC_RD;
                            end
                            else
                                state_reg <= S_RM_RD1;
                        cll_pkg::CMD_CONTAINS:
                            if (len_reg == '0)
                                state_reg <= S_VW_CUR;
                            else
                            begin
                                cnt_reg   <= len_reg;
                                addr_reg  <= cur_reg;
                                state_reg <= S_SC_RD;
                            end
                        cll_pkg::CMD_CLEAR:
                        begin
                            free_reg  <= 9'd256;
                            fresh_reg <= 9'd256;
                            len_reg   <= '0;
                            cur_reg   <= '0;
                            state_reg <= S_VW_CUR;
                        end
                        default: state_reg <= S_VW_CUR;
                    endcase
                end
                S_INS_RD:
                begin
                    // cursor links and free-stack top are valid
                    new_reg <= pop_slot;
                    if (free_reg <= fresh_reg)
                        fresh_reg <= free_reg - 9'd1;
                    free_reg <= free_reg - 9'd1;
                    if (len_reg == '0)
                    begin
                        a_reg <= pop_slot;
                        b_reg <= pop_slot;
                    end
                    else if (cmd_reg.command == cll_pkg::CMD_INS_AFTER)
                    begin
                        a_reg <= cur_reg;
                        b_reg <= rd_next_reg;
                    end
                    else
                    begin
                        a_reg <= rd_prev_reg;
                        b_reg <= cur_reg;
                    end
                    state_reg <= S_INS_W1;
                end
                S_INS_W1:
                    state_reg <= (len_reg == '0) ? S_INS_W3 : S_INS_W2;
                S_INS_W2: state_reg <= S_INS_W3;
                S_INS_W3:
                begin
                    if (len_reg == '0)
                        cur_reg <= new_reg;
                    len_reg   <= len_reg + 9'd1;
                    addr_reg  <= (len_reg == '0) ? new_reg : cur_reg;
                    state_reg <= S_VW_CUR;
                end
                S_RM_RD1:
                begin
                    // pick the victim and read its entry
                    case (cmd_reg.command)
                        cll_pkg::CMD_RM_AFTER:  tgt_reg <= rd_next_reg;
                        cll_pkg::CMD_RM_BEFORE: tgt_reg <= rd_prev_reg;
                        default:                tgt_reg <= cur_reg;
                    endcase
                    case (cmd_reg.command)
                        cll_pkg::CMD_RM_AFTER:  addr_reg <= rd_next_reg;
                        cll_pkg::CMD_RM_BEFORE: addr_reg <= rd_prev_reg;
                        default:                addr_reg <= cur_reg;
                    endcase
                    state_reg <= S_RM_RD2;
                end
                S_RM_RD2: state_reg <= S_RM_W1;
                S_RM_W1:
                begin
                    dout_reg <= rd_data_reg;
                    free_reg <= free_reg + 9'd1;
                    len_reg  <= len_reg - 9'd1;
                    if (len_reg == 9'd1)
                        cur_reg <= '0;
                    else if (tgt_reg == cur_reg)
                        cur_reg <= rd_next_reg;
                    state_reg <= S_RM_W2;
                end
                S_RM_W2:
                begin
                    addr_reg  <= cur_reg;
                    state_reg <= S_VW_CUR;
                end
                S_MOD:
                    // reduce step count modulo length
                    if (mag_reg >= {8'd0, len_reg})
                        mag_reg <= mag_reg - {8'd0, len_reg};
                    else
                    begin
                        addr_reg  <= cur_reg;
                        state_reg <= S_MV_RD;
                    end
                S_MV_RD:
                    if (mag_reg == '0)
                    begin
                        addr_reg  <= cur_reg;
                        state_reg <= S_VW_CUR;
                    end
                    else
                        state_reg <= S_MV_WAIT;
                S_MV_WAIT:
                begin
                    cur_reg   <= back_reg ? rd_prev_reg : rd_next_reg;
                    addr_reg  <= back_reg ? rd_prev_reg : rd_next_reg;
                    mag_reg   <= mag_reg - 17'd1;
                    state_reg <= S_MV_RD;
                end
                S_SC_RD: state_reg <= S_SC_WAIT;
                S_SC_WAIT:
                begin
                    if (cmd_reg.command == cll_pkg::CMD_MAX)
                    begin
                        if (rd_data_reg > acc_reg) acc_reg <= rd_data_reg;
                    end
                    else if (cmd_reg.command == cll_pkg::CMD_MIN)
                    begin
                        if (cnt_reg == len_reg || rd_data_reg < acc_reg)
                            acc_reg <= rd_data_reg;
                    end
                    else if (rd_data_reg == cmd_reg.operand_value)
                        found_reg <= 1'b1;
                    addr_reg <= rd_next_reg;
                    cnt_reg  <= cnt_reg - 9'd1;
                    if (cnt_reg == 9'd1)
                        state_reg <= S_VW_DONE;
                    else
                        state_reg <= S_SC_RD;
                end
                S_VW_DONE:
                begin
                    if (cmd_reg.command != cll_pkg::CMD_CONTAINS)
                        dout_reg <= acc_reg;
                    addr_reg  <= cur_reg;
                    state_reg <= S_VW_CUR;
                end
                S_VW_CUR:
                begin
                    addr_reg  <= cur_reg;
                    state_reg <= S_VW_PREV;
                end
                S_VW_PREV:
                begin
                    // cursor entry arrives
                    res_reg.current_word <= rd_data_reg;
                    b_reg    <= rd_next_reg;
                    addr_reg <= rd_prev_reg;
                    state_reg <= S_VW_NEXT;
                end
                S_VW_NEXT:
                begin
                    // previous entry is being read; queue the next one
                    addr_reg  <= b_reg;
                    state_reg <= S_VW_PWORD;
                end
                S_VW_PWORD:
                begin
                    res_reg.previous_word <= rd_data_reg;
                    state_reg <= S_VW_NWORD;
                end
                S_VW_NWORD:
                begin
                    // last read lands here
                    res_reg.following_word <= rd_data_reg;
                    res_reg.status         <= status_reg;
                    res_reg.data_out       <= dout_reg;
                    res_reg.found          <= found_reg;
                    res_reg.element_count  <= len_reg;
                    if (len_reg == '0)
                    begin
                        res_reg.current_word   <= '0;
                        res_reg.previous_word  <= '0;
                        res_reg.following_word <= '0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/cll_checker.sv]
// Port-level checks for the circular list block, bound to the top level.
module cll_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input cll_pkg::out_word_t out_payload
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken with result pending");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_payload.element_count <= 9'd256)
        else $error("element count out of range");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_payload.element_count == '0) |-> out_payload.current_word == '0)
        else $error("empty list shows a word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_payload))
        else $error("stalled result changed");

endmodule

bind circular_list_with_cursor_core cll_checker u_cll_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_payload (out_ch.payload)
);

[test/circular_list_with_cursor_core_tb.sv]
// Self-checking testbench for the circular list with cursor core.
module circular_list_with_cursor_core_tb;

    localparam int WatchdogLimit = 200000;
    localparam int RandomWords   = 1320;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    cll_stream_if #(.payload_t(cll_pkg::in_word_t))  in_ch ();
    cll_stream_if #(.payload_t(cll_pkg::out_word_t)) out_ch ();

    circular_list_with_cursor_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Shadow copy of the list: slot memories, free stack, cursor and limit.
    cll_pkg::word_t  sh_data [cll_pkg::Depth];
    cll_pkg::slot_t  sh_next [cll_pkg::Depth];
    cll_pkg::slot_t  sh_prev [cll_pkg::Depth];
    cll_pkg::slot_t  sh_free [cll_pkg::Depth];
    int     sh_free_cnt;
    cll_pkg::slot_t  sh_cursor;
    int     sh_len;
    int     sh_limit;

    cll_pkg::out_word_t pending_results[$];
    int        fail_count;
    int        words_sent;
    int        results_seen;
    int        idle_cycles;
    int        cmd_hits[16];

    // Directed table; a row with chk set also carries a hand-typed result.
    typedef struct {
        logic [3:0]         cmd;
        cll_pkg::word_t     val;
        logic [15:0]        step;
        logic               chk;
        cll_pkg::out_word_t exp_res;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic void shadow_clear();
        for (int i = 0; i < cll_pkg::Depth; i++)
            sh_free[i] = cll_pkg::slot_t'(cll_pkg::Depth - 1 - i);
        sh_free_cnt = cll_pkg::Depth;
        sh_cursor = '0;
        sh_len = 0;
    endfunction

    function automatic void shadow_config(logic [8:0] v);
        // Drop a nonzero limit below the present length.
        if (v != 0 && sh_len > int'(v))
            return;
        sh_limit = int'(v);
    endfunction

    function automatic void shadow_insert(cll_pkg::word_t w, bit after);
        cll_pkg::slot_t s, a, b;
        sh_free_cnt--;
        s = sh_free[sh_free_cnt];
        sh_data[s] = w;
        if (sh_len == 0)
        begin
            sh_next[s] = s;
            sh_prev[s] = s;
            sh_cursor = s;
        end
        else
        begin
            a = after ? sh_cursor : sh_prev[sh_cursor];
            b = after ? sh_next[sh_cursor] : sh_cursor;
            sh_next[s] = b;
            sh_prev[s] = a;
            sh_next[a] = s;
            sh_prev[b] = s;
        end
        sh_len++;
    endfunction

    function automatic cll_pkg::word_t shadow_unlink(cll_pkg::slot_t s);
        cll_pkg::word_t w;
        cll_pkg::slot_t a, b;
        w = sh_data[s];
        if (sh_len == 1)
        begin
            sh_cursor = '0;
        end
        else
        begin
            a = sh_prev[s];
            b = sh_next[s];
            if (s == sh_cursor)
                sh_cursor = b;
            sh_next[a] = b;
            sh_prev[b] = a;
        end
        sh_free[sh_free_cnt % cll_pkg::Depth] = s;
        sh_free_cnt++;
        sh_len--;
        return w;
    endfunction

    // Apply one command word to the shadow list and return the result word.
    function automatic cll_pkg::out_word_t list_apply(cll_pkg::in_word_t iw);
        cll_pkg::out_word_t r;
        int             mag;
        bit             back;
        cll_pkg::slot_t s;
        cll_pkg::word_t w;
        logic [3:0]     c;
        r = '0;
        c = iw.command;
        if (c == cll_pkg::CMD_INS_AFTER || c == cll_pkg::CMD_INS_BEFORE)
        begin
            if ((sh_limit > 0 && sh_len >= sh_limit) || sh_len >= cll_pkg::Depth
                || sh_free_cnt == 0)
                r.status = cll_pkg::STATUS_FULL;
            else
                shadow_insert(iw.operand_value, c == cll_pkg::CMD_INS_AFTER);
        end
        else if (c <= cll_pkg::CMD_CONTAINS && sh_len == 0)
        begin
            if (c != cll_pkg::CMD_CONTAINS)
                r.status = cll_pkg::STATUS_EMPTY;
        end
        else if (c == cll_pkg::CMD_RM_AFTER)
        begin
            r.data_out = shadow_unlink(sh_next[sh_cursor]);
        end
        else if (c == cll_pkg::CMD_RM_CURRENT)
        begin
            r.data_out = shadow_unlink(sh_cursor);
        end
        else if (c == cll_pkg::CMD_RM_BEFORE)
        begin
            r.data_out = shadow_unlink(sh_prev[sh_cursor]);
        end
        else if (c == cll_pkg::CMD_MOVE)
        begin
            back = iw.step_count[15];
            mag = back ? 65536 - int'(iw.step_count) : int'(iw.step_count);
            mag = mag % sh_len;
            for (int i = 0; i < mag; i++)
                sh_cursor = back ? sh_prev[sh_cursor] : sh_next[sh_cursor];
        end
        else if (c == cll_pkg::CMD_MAX || c == cll_pkg::CMD_MIN
                 || c == cll_pkg::CMD_CONTAINS)
        begin
            s = sh_cursor;
            r.data_out = sh_data[s];
            for (int i = 0; i < sh_len; i++)
            begin
                w = sh_data[s];
                if (c == cll_pkg::CMD_MAX && w > r.data_out) r.data_out = w;
                if (c == cll_pkg::CMD_MIN && w < r.data_out) r.data_out = w;
                if (c == cll_pkg::CMD_CONTAINS && w == iw.operand_value) r.found = 1'b1;
                s = sh_next[s];
            end
            if (c == cll_pkg::CMD_CONTAINS)
                r.data_out = '0;
        end
        else if (c == cll_pkg::CMD_CLEAR)
        begin
            shadow_clear();
        end
        r.element_count = cll_pkg::count_t'(sh_len);
        if (sh_len != 0)
        begin
            r.current_word   = sh_data[sh_cursor];
            r.previous_word  = sh_data[sh_prev[sh_cursor]];
            r.following_word = sh_data[sh_next[sh_cursor]];
        end
        return r;
    endfunction

    // Send one word: random gap first at burst edges, then hold until taken.
    int burst_left;

    task automatic send_word(cll_pkg::in_word_t iw, bit has_hand,
                             cll_pkg::out_word_t hand);
        cll_pkg::out_word_t p;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        p = list_apply(iw);
        if (has_hand && p !== hand)
        begin
            $error("directed row %0d: table expectation %h, shadow %h", words_sent, hand, p);
            fail_count++;
        end
        pending_results.push_back(p);
        cmd_hits[iw.command]++;
        in_ch.valid   <= 1'b1;
        in_ch.payload <= iw;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    // Write the limit once the block has drained its results.
    task automatic write_limit(logic [8:0] v);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_config(v);
    endtask

    function automatic cll_pkg::in_word_t mk(logic [3:0] c, cll_pkg::word_t v,
                                             logic [15:0] st);
        cll_pkg::in_word_t iw;
        iw.command = c;
        iw.operand_value = v;
        iw.step_count = st;
        return iw;
    endfunction

    function automatic void add_row(logic [3:0] c, cll_pkg::word_t v, logic [15:0] st,
                                    bit chk, cll_pkg::out_word_t r);
        dir_row_t d;
        d.cmd = c;
        d.val = v;
        d.step = st;
        d.chk = chk;
        d.exp_res = r;
        dir_rows.push_back(d);
    endfunction

    function automatic cll_pkg::out_word_t res(logic [1:0] st, cll_pkg::word_t d,
                                               cll_pkg::count_t n, cll_pkg::word_t cur,
                                               cll_pkg::word_t pv, cll_pkg::word_t nx);
        cll_pkg::out_word_t r;
        r = '0;
        r.status = st;
        r.data_out = d;
        r.element_count = n;
        r.current_word = cur;
        r.previous_word = pv;
        r.following_word = nx;
        return r;
    endfunction

    // Pick a random command word; weights favor inserts so the ring grows.
    function automatic cll_pkg::in_word_t rand_word();
        int k;
        logic [3:0] c;
        cll_pkg::word_t v;
        logic [15:0] st;
        k = $urandom_range(0, 99);
        if (k < 30)      c = cll_pkg::CMD_INS_AFTER;
        else if (k < 50) c = cll_pkg::CMD_INS_BEFORE;
        else if (k < 56) c = cll_pkg::CMD_RM_AFTER;
        else if (k < 62) c = cll_pkg::CMD_RM_CURRENT;
        else if (k < 68) c = cll_pkg::CMD_RM_BEFORE;
        else if (k < 80) c = cll_pkg::CMD_MOVE;
        else if (k < 85) c = cll_pkg::CMD_MAX;
        else if (k < 90) c = cll_pkg::CMD_MIN;
        else if (k < 96) c = cll_pkg::CMD_CONTAINS;
        else if (k < 98) c = cll_pkg::CMD_CLEAR;
        else             c = 4'($urandom_range(10, 15));
        v = ($urandom_range(0, 3) == 0) ? cll_pkg::word_t'($urandom_range(0, 15))
                                        : cll_pkg::word_t'($urandom);
        // Contains often asks for a word that is in the ring.
        if (c == cll_pkg::CMD_CONTAINS && sh_len != 0 && $urandom_range(0, 1))
            v = sh_data[sh_cursor];
        // Mostly short moves, a few across the full range.
        st = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                         : 16'($signed($urandom_range(0, 20)) - 10);
        return mk(c, v, st);
    endfunction

    // Result side: stall on its own pattern, check each word against the queue.
    initial
    begin
        cll_pkg::out_word_t e;
        int stall_mode;
        out_ch.ready = 1'b0;
        stall_mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (out_ch.payload.status !== e.status)
                    begin
                        $error("status: expected %0d actual %0d", e.status,
                               out_ch.payload.status);
                        fail_count++;
                    end
                    if (out_ch.payload.data_out !== e.data_out)
                    begin
                        $error("data_out: expected %h actual %h", e.data_out,
                               out_ch.payload.data_out);
                        fail_count++;
                    end
                    if (out_ch.payload.found !== e.found)
                    begin
                        $error("found: expected %0d actual %0d", e.found,
                               out_ch.payload.found);
                        fail_count++;
                    end
                    if (out_ch.payload.element_count !== e.element_count)
                    begin
                        $error("element_count: expected %0d actual %0d", e.element_count,
                               out_ch.payload.element_count);
                        fail_count++;
                    end
                    if (out_ch.payload.current_word !== e.current_word)
                    begin
                        $error("current_word: expected %h actual %h", e.current_word,
                               out_ch.payload.current_word);
                        fail_count++;
                    end
                    if (out_ch.payload.previous_word !== e.previous_word)
                    begin
                        $error("previous_word: expected %h actual %h", e.previous_word,
                               out_ch.payload.previous_word);
                        fail_count++;
                    end
                    if (out_ch.payload.following_word !== e.following_word)
                    begin
                        $error("following_word: expected %h actual %h", e.following_word,
                               out_ch.payload.following_word);
                        fail_count++;
                    end
                end
            end
            // Alternate between stretches of steady ready and choppy stalls.
            if ($urandom_range(0, 63) == 0)
                stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: count cycles with no handshake on either side.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        cll_pkg::word_t top;
        logic [8:0] lim_vals[6];
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        fail_count = 0;
        words_sent = 0;
        results_seen = 0;
        burst_left = 0;
        for (int i = 0; i < 16; i++) cmd_hits[i] = 0;
        for (int i = 0; i < cll_pkg::Depth; i++)
        begin
            sh_data[i] = '0;
            sh_next[i] = '0;
            sh_prev[i] = '0;
        end
        shadow_clear();
        sh_limit = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        top = '1;
        // Empty-list cases, then the extremes of the words and steps.
        add_row(cll_pkg::CMD_RM_AFTER,   0, 0, 1, res(cll_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
        add_row(cll_pkg::CMD_RM_CURRENT, 0, 0, 1, res(cll_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
        add_row(cll_pkg::CMD_RM_BEFORE,  0, 0, 1, res(cll_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
        add_row(cll_pkg::CMD_MOVE, 0, 16'h7fff, 1,
                res(cll_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
        add_row(cll_pkg::CMD_MAX,        0, 0, 1, res(cll_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
        add_row(cll_pkg::CMD_MIN,        0, 0, 1, res(cll_pkg::STATUS_EMPTY, 0, 0, 0, 0, 0));
        add_row(cll_pkg::CMD_CONTAINS,   0, 0, 1, res(cll_pkg::STATUS_OK, 0, 0, 0, 0, 0));
        add_row(cll_pkg::CMD_INS_BEFORE, top, 0, 1,
                res(cll_pkg::STATUS_OK, 0, 1, top, top, top));
        add_row(cll_pkg::CMD_INS_AFTER,  0, 0, 1, res(cll_pkg::STATUS_OK, 0, 2, top, 0, 0));
        add_row(cll_pkg::CMD_INS_AFTER,  32'h5a5a_a5a5, 0, 0, '0);
        add_row(cll_pkg::CMD_MAX,        0, 0, 0, '0);
        add_row(cll_pkg::CMD_MIN,        0, 0, 0, '0);
        add_row(cll_pkg::CMD_CONTAINS,   32'h5a5a_a5a5, 0, 0, '0);
        add_row(cll_pkg::CMD_CONTAINS,   32'h1234_5678, 0, 0, '0);
        add_row(cll_pkg::CMD_MOVE,       0, 16'h8000, 0, '0);
        add_row(cll_pkg::CMD_MOVE,       0, 16'h7fff, 0, '0);
        add_row(cll_pkg::CMD_MOVE,       0, 16'hffff, 0, '0);
        add_row(cll_pkg::CMD_RM_CURRENT, 0, 0, 0, '0);
        add_row(4'd15,                   top, 16'hffff, 0, '0);
        add_row(cll_pkg::CMD_RM_BEFORE,  0, 0, 0, '0);
        add_row(cll_pkg::CMD_RM_AFTER,   0, 0, 0, '0);
        add_row(cll_pkg::CMD_INS_AFTER,  7, 0, 0, '0);
        add_row(cll_pkg::CMD_CLEAR,      0, 0, 1, res(cll_pkg::STATUS_OK, 0, 0, 0, 0, 0));
        foreach (dir_rows[i])
            send_word(mk(dir_rows[i].cmd, dir_rows[i].val, dir_rows[i].step),
                      dir_rows[i].chk, dir_rows[i].exp_res);

        // Limit of one: second insert is refused as full.
        write_limit(9'd1);
        send_word(mk(cll_pkg::CMD_INS_AFTER, 1, 0), 1,
                  res(cll_pkg::STATUS_OK, 0, 1, 1, 1, 1));
        send_word(mk(cll_pkg::CMD_INS_BEFORE, 2, 0), 1,
                  res(cll_pkg::STATUS_FULL, 0, 1, 1, 1, 1));

        // Random phases under several limits, the extremes among them.
        lim_vals = '{9'd0, 9'd256, 9'd3, 9'd511, 9'd40, 9'd0};
        foreach (lim_vals[p])
        begin
            write_limit(lim_vals[p]);
            for (int n = 0; n < RandomWords / 6; n++)
                send_word(rand_word(), 0, '0);
        end

        // Fill to capacity with no limit, then one more insert overflows.
        write_limit(9'd0);
        while (sh_len < cll_pkg::Depth)
            send_word(mk(cll_pkg::CMD_INS_AFTER, cll_pkg::word_t'($urandom), 0), 0, '0);
        send_word(mk(cll_pkg::CMD_INS_BEFORE, 0, 0), 0, '0);
        send_word(mk(cll_pkg::CMD_MAX, 0, 0), 0, '0);
        write_limit(9'd5);
        send_word(mk(cll_pkg::CMD_MOVE, 0, 16'h8000), 0, '0);
        send_word(mk(cll_pkg::CMD_CLEAR, 0, 0), 0, '0);

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d command words, checked %0d results, final length limit %0d",
                 words_sent, results_seen, sh_limit);
        $display("inserts %0d, removes %0d, moves %0d, scans %0d, clears %0d",
                 cmd_hits[cll_pkg::CMD_INS_AFTER] + cmd_hits[cll_pkg::CMD_INS_BEFORE],
                 cmd_hits[cll_pkg::CMD_RM_AFTER] + cmd_hits[cll_pkg::CMD_RM_CURRENT]
                 + cmd_hits[cll_pkg::CMD_RM_BEFORE],
                 cmd_hits[cll_pkg::CMD_MOVE],
                 cmd_hits[cll_pkg::CMD_MAX] + cmd_hits[cll_pkg::CMD_MIN]
                 + cmd_hits[cll_pkg::CMD_CONTAINS],
                 cmd_hits[cll_pkg::CMD_CLEAR]);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
